// File: hdl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared codes for the Plummer truncated acceleration core.
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

  typedef enum logic [1:0] {
    CFG_GRAV_MASS    = 2'd0,
    CFG_HALO_RADIUS  = 2'd1,
    CFG_TRUNC_RADIUS = 2'd2,
    CFG_TRUNC_ENABLE = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: hdl/plm_mul_chain.sv
// ----------------------------------------------------------------------------
// plm_mul_chain
// Shift-add multiplier built as a row of cells, one multiplier bit per cell,
// with a side lane carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_mul_chain #(
  parameter int XW = 32,
  parameter int YW = 32,
  parameter int CW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [XW-1:0]    x_i,
  input  wire logic [YW-1:0]    y_i,
  input  wire logic [CW-1:0]    ctx_i,
  output logic                  valid_o,
  output logic [XW+YW-1:0]      p_o,
  output logic [CW-1:0]         ctx_o
);

  localparam int PW = XW + YW;

  logic          valid_q [YW];
  logic [XW-1:0] x_q     [YW];
  logic [YW-1:0] y_q     [YW];
  logic [PW-1:0] acc_q   [YW];
  logic [CW-1:0] ctx_q   [YW];

  for (genvar i = 0; i < YW; i++) begin : g_cell
    logic          v_in;
    logic [XW-1:0] x_in;
    logic [YW-1:0] y_in;
    logic [PW-1:0] acc_in;
    logic [CW-1:0] ctx_in;

    if (i == 0) begin : g_head
      assign v_in   = valid_i;
      assign x_in   = x_i;
      assign y_in   = y_i;
      assign acc_in = '0;
      assign ctx_in = ctx_i;
    end else begin : g_link
      assign v_in   = valid_q[i-1];
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign acc_in = acc_q[i-1];
      assign ctx_in = ctx_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]   <= x_in;
        y_q[i]   <= y_in;
        ctx_q[i] <= ctx_in;
        acc_q[i] <= acc_in + (y_in[i] ? (PW'(x_in) << i) : '0);
      end
    end
  end

  assign valid_o = valid_q[YW-1];
  assign p_o     = acc_q[YW-1];
  assign ctx_o   = ctx_q[YW-1];

endmodule

`default_nettype wire

// File: hdl/plm_sqrt_chain.sv
// ----------------------------------------------------------------------------
// plm_sqrt_chain
// Integer floor square root as a row of cells, one root bit per cell,
// with a side lane carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_sqrt_chain #(
  parameter int SW = 65,
  parameter int RW = 33,
  parameter int CW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [SW-1:0] s_i,
  input  wire logic [CW-1:0] ctx_i,
  output logic               valid_o,
  output logic [RW-1:0]      root_o,
  output logic [CW-1:0]      ctx_o
);

  localparam int QW2 = 2 * RW + 1;

  logic            valid_q [RW];
  logic [SW-1:0]   s_q     [RW];
  logic [RW-1:0]   root_q  [RW];
  logic [2*RW-1:0] sq_q    [RW];
  logic [CW-1:0]   ctx_q   [RW];

  for (genvar i = 0; i < RW; i++) begin : g_cell
    localparam int B = RW - 1 - i;
    logic            v_in;
    logic [SW-1:0]   s_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] sq_in;
    logic [CW-1:0]   ctx_in;
    logic [QW2-1:0]  cand;
    logic            take;

    if (i == 0) begin : g_head
      assign v_in    = valid_i;
      assign s_in    = s_i;
      assign root_in = '0;
      assign sq_in   = '0;
      assign ctx_in  = ctx_i;
    end else begin : g_link
      assign v_in    = valid_q[i-1];
      assign s_in    = s_q[i-1];
      assign root_in = root_q[i-1];
      assign sq_in   = sq_q[i-1];
      assign ctx_in  = ctx_q[i-1];
    end

    // (root + 2^b)^2 = root^2 + root * 2^(b+1) + 2^(2b)
    assign cand = QW2'(sq_in) + (QW2'(root_in) << (B + 1)) + (QW2'(1) << (2 * B));
    assign take = cand <= QW2'(s_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i]    <= s_in;
        ctx_q[i]  <= ctx_in;
        root_q[i] <= take ? (root_in | (RW'(1) << B)) : root_in;
        sq_q[i]   <= take ? cand[2*RW-1:0] : sq_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign ctx_o   = ctx_q[RW-1];

endmodule

`default_nettype wire

// File: hdl/plm_div_chain.sv
// ----------------------------------------------------------------------------
// plm_div_chain
// Restoring divider as a row of cells: a head cell checks for quotient
// overflow, then one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_div_chain #(
  parameter int NW = 260,
  parameter int DW = 258,
  parameter int QW = 32,
  parameter int CW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [CW-1:0] ctx_i,
  output logic               valid_o,
  output logic [QW-1:0]      quot_o,
  output logic               ovf_o,
  output logic [CW-1:0]      ctx_o
);

  localparam int HW = NW - QW;
  localparam int MW = (HW > DW) ? HW : DW;

  logic          valid_q [QW+1];
  logic [DW-1:0] rem_q   [QW+1];
  logic [DW-1:0] den_q   [QW+1];
  logic [QW-1:0] lo_q    [QW+1];
  logic [QW-1:0] quot_q  [QW+1];
  logic          ovf_q   [QW+1];
  logic [CW-1:0] ctx_q   [QW+1];

  logic [HW-1:0] hi;
  logic          hi_ovf;
  logic [MW-1:0] hi_ext;

  assign hi     = num_i[NW-1:QW];
  assign hi_ext = MW'(hi);
  assign hi_ovf = hi_ext >= MW'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= hi_ovf ? '0 : hi_ext[DW-1:0];
      den_q[0]  <= den_i;
      lo_q[0]   <= num_i[QW-1:0];
      quot_q[0] <= '0;
      ovf_q[0]  <= hi_ovf;
      ctx_q[0]  <= ctx_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_cell
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;

    assign r2   = {rem_q[k-1], lo_q[k-1][QW-k]};
    assign ge   = r2 >= {1'b0, den_q[k-1]};
    assign diff = r2 - {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
        den_q[k]  <= den_q[k-1];
        lo_q[k]   <= lo_q[k-1];
        quot_q[k] <= (quot_q[k-1] << 1) | QW'(ge);
        ovf_q[k]  <= ovf_q[k-1];
        ctx_q[k]  <= ctx_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign quot_o  = quot_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign ctx_o   = ctx_q[QW];

endmodule

`default_nettype wire

// File: hdl/plummer_truncated_acceleration_core.sv
// ----------------------------------------------------------------------------
// plummer_truncated_acceleration_core
// One axis of Plummer halo acceleration with optional truncation, Q fixed
// point, built from rows of multiplier, square root and divider cells.
//
// Input stream s_axis carries radius, coord and centre_coord; output stream
// m_axis carries accel in tdata and range_error in tuser. One request is
// taken per cycle while the output is not stalled and the config rows have
// settled. A request passes the input register, the r^2, square root,
// divisor/dividend and divider cell rows, then the output register.
// The cfg channel is always ready; writes are to be made only while no
// request is in flight.
// After reset and after every cfg write a busy counter holds s_axis_tready
// low while the config rows settle.
// When the receiver stalls the output register holds its result and the
// rows keep moving until a finished result reaches the last divider cell;
// then the whole row freezes and s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module plummer_truncated_acceleration_core #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // radius, coord, centre_coord
  input  wire logic [((3*WORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // accel
  output logic [((WORD_WIDTH+7)/8)*8-1:0]               m_axis_tdata,
  // range_error
  output logic [0:0]                                    m_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  input  wire logic                                     cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  wire logic [1:0]                               cfg_index_i,
  input  wire logic [WORD_WIDTH-1:0]                    cfg_data_i
);

  localparam int W      = WORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int ODW    = ((W + 7) / 8) * 8;
  localparam int XKW    = 5 * W + 2;
  localparam int NNW    = 3 * W + 3;
  localparam int NYW    = NNW + 2 * F;
  localparam int DW     = 8 * W + 2;
  localparam int NPW    = 2 * W + 1 + NYW;
  localparam int NUMW   = NPW + 2 * F;
  localparam int CFG_LAT = 5 * W + 4;
  localparam int BW     = $clog2(CFG_LAT + 1);

  // configuration registers
  logic [W-1:0] grav_mass_q, halo_radius_q, trunc_radius_q;
  logic         trunc_enable_q;
  logic [BW-1:0] busy_q;
  logic          cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_mass_q    <= W'(1) << F;
      halo_radius_q  <= W'(1) << F;
      trunc_radius_q <= '0;
      trunc_enable_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        plm_pkg::CFG_GRAV_MASS:    grav_mass_q    <= cfg_data_i;
        plm_pkg::CFG_HALO_RADIUS:  halo_radius_q  <= cfg_data_i;
        plm_pkg::CFG_TRUNC_RADIUS: trunc_radius_q <= cfg_data_i;
        plm_pkg::CFG_TRUNC_ENABLE: trunc_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= BW'(CFG_LAT);
    end else if (cfg_wr) begin
      busy_q <= BW'(CFG_LAT);
    end else if (busy_q != '0) begin
      busy_q <= busy_q - BW'(1);
    end
  end

  // config-derived constants: a^2, N = 3a^2 rt + 2 rt^3, K = a^2 U sqrt(U)
  logic [2*W-1:0]   c_a2, c_t2;
  logic [W-1:0]     c_t1;
  logic [2*W:0]     c_u;
  logic [W:0]       c_v;
  logic [2*W-1:0]   c_a2b, c_t2b;
  logic [W-1:0]     c_tb;
  logic [2*W:0]     c_ub;
  logic [3*W:0]     c_a2t, c_t3;
  logic [3*W+1:0]   c_uv;
  logic [2*W-1:0]   c_a2c;
  logic [NNW-1:0]   c_n, k_n;
  logic [XKW-1:0]   k_k;

  plm_mul_chain #(.XW(W), .YW(W), .CW(W)) u_cfg_a2 (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1),
    .x_i(halo_radius_q), .y_i(halo_radius_q), .ctx_i(trunc_radius_q),
    .valid_o(), .p_o(c_a2), .ctx_o(c_t1)
  );

  plm_mul_chain #(.XW(W), .YW(W), .CW(1)) u_cfg_t2 (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1),
    .x_i(trunc_radius_q), .y_i(trunc_radius_q), .ctx_i(1'b0),
    .valid_o(), .p_o(c_t2), .ctx_o()
  );

  assign c_u = (2*W+1)'(c_a2) + (2*W+1)'(c_t2);

  plm_sqrt_chain #(.SW(2*W+1), .RW(W+1), .CW(7*W+1)) u_cfg_v (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1),
    .s_i(c_u), .ctx_i({c_a2, c_t2, c_t1, c_u}),
    .valid_o(), .root_o(c_v), .ctx_o({c_a2b, c_t2b, c_tb, c_ub})
  );

  plm_mul_chain #(.XW(2*W), .YW(W+1), .CW(1)) u_cfg_a2t (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1),
    .x_i(c_a2b), .y_i((W+1)'(c_tb)), .ctx_i(1'b0),
    .valid_o(), .p_o(c_a2t), .ctx_o()
  );

  plm_mul_chain #(.XW(2*W), .YW(W+1), .CW(1)) u_cfg_t3 (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1),
    .x_i(c_t2b), .y_i((W+1)'(c_tb)), .ctx_i(1'b0),
    .valid_o(), .p_o(c_t3), .ctx_o()
  );

  plm_mul_chain #(.XW(2*W+1), .YW(W+1), .CW(2*W)) u_cfg_uv (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1),
    .x_i(c_ub), .y_i(c_v), .ctx_i(c_a2b),
    .valid_o(), .p_o(c_uv), .ctx_o(c_a2c)
  );

  assign c_n = (NNW'(c_a2t) << 1) + NNW'(c_a2t) + (NNW'(c_t3) << 1);

  plm_mul_chain #(.XW(3*W+2), .YW(2*W), .CW(NNW)) u_cfg_k (
    .clk_i, .rst_ni, .en_i(1'b1), .valid_i(1'b1),
    .x_i(c_uv), .y_i(c_a2c), .ctx_i(c_n),
    .valid_o(), .p_o(k_k), .ctx_o(k_n)
  );

  // item path
  logic en;
  logic div_valid;
  logic out_valid_q;

  assign en            = !(div_valid && out_valid_q && !m_axis_tready);
  assign s_axis_tready = en && (busy_q == '0);

  logic [W-1:0] in_radius, in_coord, in_centre;
  logic [W:0]   in_d, in_dmag;
  logic         in_dpos, in_trunc;

  assign in_radius = s_axis_tdata[W-1:0];
  assign in_coord  = s_axis_tdata[2*W-1:W];
  assign in_centre = s_axis_tdata[3*W-1:2*W];
  assign in_d      = {in_coord[W-1], in_coord} - {in_centre[W-1], in_centre};
  assign in_dpos   = !in_d[W] && (in_d != '0);
  assign in_dmag   = in_d[W] ? (~in_d + (W+1)'(1)) : in_d;
  assign in_trunc  = trunc_enable_q && !(in_radius < trunc_radius_q);

  logic         e_valid_q;
  logic [W-1:0] e_radius_q;
  logic [W:0]   e_dmag_q;
  logic         e_dpos_q, e_trunc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= s_axis_tvalid && (busy_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_radius_q <= in_radius;
      e_dmag_q   <= in_dmag;
      e_dpos_q   <= in_dpos;
      e_trunc_q  <= in_trunc;
    end
  end

  // r^2
  logic           a_valid;
  logic [2*W-1:0] a_r2;
  logic [W-1:0]   a_radius;
  logic [W:0]     a_dmag;
  logic           a_dpos, a_trunc;
  logic [2*W:0]   a_s;

  plm_mul_chain #(.XW(W), .YW(W), .CW(2*W+3)) u_r2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(e_valid_q),
    .x_i(e_radius_q), .y_i(e_radius_q),
    .ctx_i({e_trunc_q, e_dpos_q, e_dmag_q, e_radius_q}),
    .valid_o(a_valid), .p_o(a_r2), .ctx_o({a_trunc, a_dpos, a_dmag, a_radius})
  );

  assign a_s = (2*W+1)'(c_a2) + (2*W+1)'(a_r2);

  // sqrt(a^2 + r^2), r^3 and GM |D| side by side
  logic           b_valid;
  logic [W:0]     b_q;
  logic [2*W:0]   b_s;
  logic           b_dpos, b_trunc;
  logic [3*W:0]   b_r3;
  logic [2*W:0]   b_p;

  plm_sqrt_chain #(.SW(2*W+1), .RW(W+1), .CW(2*W+3)) u_sq (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_valid),
    .s_i(a_s), .ctx_i({a_trunc, a_dpos, a_s}),
    .valid_o(b_valid), .root_o(b_q), .ctx_o({b_trunc, b_dpos, b_s})
  );

  plm_mul_chain #(.XW(2*W), .YW(W+1), .CW(1)) u_r3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_valid),
    .x_i(a_r2), .y_i((W+1)'(a_radius)), .ctx_i(1'b0),
    .valid_o(), .p_o(b_r3), .ctx_o()
  );

  plm_mul_chain #(.XW(W), .YW(W+1), .CW(1)) u_md (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_valid),
    .x_i(grav_mass_q), .y_i(a_dmag), .ctx_i(1'b0),
    .valid_o(), .p_o(b_p), .ctx_o()
  );

  // divisor and dividend
  logic [XKW-1:0]     b_den_x;
  logic [NYW-1:0]     b_den_y, b_num_y;
  logic               c_valid, c_dpos;
  logic [XKW+NYW-1:0] c_den_p;
  logic [NPW-1:0]     c_num_p;
  logic [DW-1:0]      c_den;
  logic [NUMW-1:0]    c_num;
  logic               c_dzero;

  assign b_den_x = b_trunc ? k_k : XKW'(b_s);
  assign b_den_y = b_trunc ? NYW'(b_r3) : NYW'(b_q);
  assign b_num_y = b_trunc ? {k_n, (2*F)'(0)} : NYW'(1);

  plm_mul_chain #(.XW(XKW), .YW(NYW), .CW(1)) u_den (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b_valid),
    .x_i(b_den_x), .y_i(b_den_y), .ctx_i(b_dpos),
    .valid_o(c_valid), .p_o(c_den_p), .ctx_o(c_dpos)
  );

  plm_mul_chain #(.XW(2*W+1), .YW(NYW), .CW(1)) u_num (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b_valid),
    .x_i(b_p), .y_i(b_num_y), .ctx_i(1'b0),
    .valid_o(), .p_o(c_num_p), .ctx_o()
  );

  assign c_den   = c_den_p[DW-1:0];
  assign c_num   = {c_num_p, (2*F)'(0)};
  assign c_dzero = (c_den == '0);

  logic [W-1:0] d_quot;
  logic         d_ovf, d_dpos, d_dzero;

  plm_div_chain #(.NW(NUMW), .DW(DW), .QW(W), .CW(2)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_valid),
    .num_i(c_num), .den_i(c_den), .ctx_i({c_dpos, c_dzero}),
    .valid_o(div_valid), .quot_o(d_quot), .ovf_o(d_ovf), .ctx_o({d_dpos, d_dzero})
  );

  // saturation, sign and output register
  logic [W-1:0] limit, mag, accel_d;
  logic         sat, err_d;
  logic [W-1:0] accel_q;
  logic         err_q;

  assign limit   = (W'(1) << (W - 1)) - (d_dpos ? W'(0) : W'(1));
  assign sat     = d_ovf || (d_quot > limit);
  assign mag     = sat ? limit : d_quot;
  assign accel_d = d_dzero ? '0 : (d_dpos ? (~mag + W'(1)) : mag);
  assign err_d   = d_dzero || sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && div_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && div_valid) begin
      accel_q <= accel_d;
      err_q   <= err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'(accel_q);
  assign m_axis_tuser  = err_q;

endmodule

`default_nettype wire

// File: bench/tb_plummer_truncated_acceleration_core.sv
// ----------------------------------------------------------------------------
// tb_plummer_truncated_acceleration_core
// Self-checking bench for the Plummer truncated acceleration core. A short
// table of directed requests and register writes runs first, then random
// requests under three idle patterns on the input and output streams. Every
// result is compared in order of acceptance with an exact wide-integer
// prediction of the axis acceleration or, for pinned directed rows, a fixed value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_plummer_truncated_acceleration_core;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_PER_SET = 78;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_CFG_DONE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    plm_pkg::cfg_idx_e idx;
    logic [31:0]       value;
    logic [31:0]       radius;
    logic [31:0]       coord;
    logic [31:0]       centre;
    bit                pinned;
    logic [31:0]       accel;
    logic              range_err;
  } row_t;

  typedef struct {
    logic [31:0] accel;
    logic        range_err;
  } accel_t;

  logic        clk_i;
  logic        rst_ni;
  logic [95:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  logic [31:0] grav_mass, halo_radius, trunc_radius;
  logic        trunc_enable;

  accel_t pending_accel_q[$];
  int     errors;
  int     results_seen;
  int     cycles;
  int     send_idle_pct;
  int     recv_idle_pct;

  plummer_truncated_acceleration_core #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_WIDTH(WORD_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] floor_sqrt(logic [511:0] s);
    logic [63:0]  root;
    logic [63:0]  t;
    logic [511:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      t = root | (64'd1 << b);
      sq = 512'(t) * 512'(t);
      if (sq <= s) root = t;
    end
    return root;
  endfunction

  function automatic accel_t axis_accel(logic [31:0] r, logic [31:0] x, logic [31:0] x0);
    accel_t      res;
    logic [32:0] d;
    logic [32:0] dmag;
    logic [511:0] m, a, t, rr, a2, t2, u, s, nt, num, den, quo, lim;
    d = {x[31], x} - {x0[31], x0};
    dmag = d[32] ? -d : d;
    m = 512'(grav_mass);
    a = 512'(halo_radius);
    t = 512'(trunc_radius);
    rr = 512'(r);
    a2 = a * a;
    num = (m * 512'(dmag)) << (2 * FRAC_BITS);
    if (!trunc_enable || r < trunc_radius) begin
      s = a2 + rr * rr;
      den = s * 512'(floor_sqrt(s));
    end else begin
      t2 = t * t;
      u = a2 + t2;
      nt = 512'(3) * a2 * t + 512'(2) * t2 * t;
      num = (num * nt) << (2 * FRAC_BITS);
      den = a2 * rr * rr * rr * u * 512'(floor_sqrt(u));
    end
    if (den == '0) begin
      res.accel = '0;
      res.range_err = 1'b1;
      return res;
    end
    quo = num / den;
    lim = (d[32] || d == '0) ? 512'(32'h7fff_ffff) : 512'(32'h8000_0000);
    res.range_err = quo > lim;
    if (res.range_err) quo = lim;
    res.accel = (!d[32] && d != '0) ? -quo[31:0] : quo[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_plummer_truncated_acceleration_core failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    accel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_accel_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = pending_accel_q.pop_front();
        if (m_axis_tdata !== want.accel) report_mismatch("accel", m_axis_tdata, want.accel);
        if (m_axis_tuser[0] !== want.range_err)
          report_mismatch("range_error", 32'(m_axis_tuser), 32'(want.range_err));
      end
    end
  end

  task automatic send_request(logic [31:0] r, logic [31:0] x, logic [31:0] x0,
                              bit pinned, accel_t typed);
    cfg_valid_i <= 1'b0;
    s_axis_tdata <= {x0, x, r};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_accel_q.push_back(pinned ? typed : axis_accel(r, x, x0));
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_accel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(plm_pkg::cfg_idx_e idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      plm_pkg::CFG_GRAV_MASS:    grav_mass = value;
      plm_pkg::CFG_HALO_RADIUS:  halo_radius = value;
      plm_pkg::CFG_TRUNC_RADIUS: trunc_radius = value;
      plm_pkg::CFG_TRUNC_ENABLE: trunc_enable = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom();
      default: return $urandom_range(32'h1000, 32'h10_0000);
    endcase
  endfunction

  function automatic row_t item_row(logic [31:0] r, logic [31:0] x, logic [31:0] x0,
                                    bit pinned = 0, logic [31:0] acc = '0,
                                    logic err = 1'b0);
    row_t row;
    row = '{ROW_ITEM, plm_pkg::CFG_GRAV_MASS, '0, r, x, x0, pinned, acc, err};
    return row;
  endfunction

  function automatic row_t cfg_row(plm_pkg::cfg_idx_e idx, logic [31:0] value);
    row_t row;
    row = '{ROW_CFG, idx, value, '0, '0, '0, 1'b0, '0, 1'b0};
    return row;
  endfunction

  initial begin
    row_t        directed[$];
    accel_t      typed;
    logic [31:0] r, x, x0;
    bit          in_cfg;

    rst_ni = 1'b0;
    s_axis_tdata = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = plm_pkg::CFG_GRAV_MASS;
    cfg_data_i = '0;
    errors = 0;
    results_seen = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    grav_mass = 32'h1_0000;
    halo_radius = 32'h1_0000;
    trunc_radius = '0;
    trunc_enable = 1'b0;

    directed = '{
      item_row(32'h0, 32'h0, 32'h0, 1, 32'h0, 1'b0),
      item_row(32'h0, 32'h1, 32'h0, 1, 32'hffff_ffff, 1'b0),
      item_row(32'h0, 32'h0, 32'h1, 1, 32'h1, 1'b0),
      item_row(32'h0, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h8000_0000, 1'b1),
      item_row(32'h0, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1'b1),
      item_row(32'hffff_ffff, 32'h1_0000, 32'h0),
      item_row(32'h2_0000, 32'hfffd_0000, 32'h2_0000),
      cfg_row(plm_pkg::CFG_GRAV_MASS, 32'hffff_ffff),
      item_row(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000),
      item_row(32'h8000, 32'h0, 32'h5_5555),
      cfg_row(plm_pkg::CFG_HALO_RADIUS, 32'h0),
      item_row(32'h0, 32'h1, 32'h0, 1, 32'h0, 1'b1),
      item_row(32'h1_0000, 32'h1, 32'h0),
      cfg_row(plm_pkg::CFG_TRUNC_ENABLE, 32'h1),
      item_row(32'h5, 32'h1, 32'h0, 1, 32'h0, 1'b1),
      cfg_row(plm_pkg::CFG_HALO_RADIUS, 32'h1_0000),
      cfg_row(plm_pkg::CFG_GRAV_MASS, 32'h1_0000),
      item_row(32'h0, 32'h1, 32'h0, 1, 32'h0, 1'b1),
      item_row(32'h2_0000, 32'h1, 32'h0, 1, 32'h0, 1'b0),
      cfg_row(plm_pkg::CFG_TRUNC_RADIUS, 32'h2_0000),
      item_row(32'h1_ffff, 32'h3_0000, 32'h0),
      item_row(32'h2_0000, 32'h3_0000, 32'h0),
      item_row(32'hffff_ffff, 32'hfff0_0000, 32'h0),
      cfg_row(plm_pkg::CFG_TRUNC_RADIUS, 32'hffff_ffff),
      item_row(32'hffff_ffff, 32'h1_0000, 32'h0),
      item_row(32'hffff_fffe, 32'h1_0000, 32'h0),
      cfg_row(plm_pkg::CFG_TRUNC_ENABLE, 32'h0),
      cfg_row(plm_pkg::CFG_HALO_RADIUS, 32'hffff_ffff),
      item_row(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_cfg = 0;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (!in_cfg) wait_idle();
        in_cfg = 1;
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        in_cfg = 0;
        typed.accel = directed[i].accel;
        typed.range_err = directed[i].range_err;
        send_request(directed[i].radius, directed[i].coord, directed[i].centre,
                     directed[i].pinned, typed);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 55 : 0;
      recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 27 : 0;
      for (int set = 0; set < 3; set++) begin
        wait_idle();
        write_reg(plm_pkg::CFG_GRAV_MASS, pick_reg());
        write_reg(plm_pkg::CFG_HALO_RADIUS, pick_reg());
        write_reg(plm_pkg::CFG_TRUNC_RADIUS, pick_reg());
        write_reg(plm_pkg::CFG_TRUNC_ENABLE, 32'($urandom_range(0, 1)));
        for (int k = 0; k < RANDOM_PER_SET; k++) begin
          case ($urandom_range(0, 9))
            0, 1: r = $urandom();
            2, 3, 4: r = trunc_radius + 32'($signed($urandom_range(0, 64)) - 32);
            default: r = $urandom_range(0, 32'h20_0000);
          endcase
          x0 = $urandom();
          if ($urandom_range(0, 9) < 6) x = x0 + 32'($signed($urandom_range(0, 32'h8_0000))
                                                 - 32'sh4_0000);
          else x = $urandom();
          send_request(r, x, x0, 0, typed);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_accel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d results over directed extremes and nine random register sets",
             results_seen);
    $display("idle patterns: sender-heavy, receiver-heavy and none; %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb_plummer_truncated_acceleration_core passed");
    end else begin
      $display("tb_plummer_truncated_acceleration_core failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
